// ===== src/touch_zone_hit_matcher_assert.svh =====
// Assertion macros for the touch zone hit matcher.
`ifndef TOUCH_ZONE_HIT_MATCHER_ASSERT_SVH
`define TOUCH_ZONE_HIT_MATCHER_ASSERT_SVH
`ifndef SYNTH
// Implication checked on every clock edge out of reset.
`define TZHM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Condition that must hold on every clock edge out of reset.
`define TZHM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`else
`define TZHM_ASSERT_IMPL(lbl, ante, cons, msg)
`define TZHM_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

// ===== src/tzhm_pkg.sv =====
// Shared types and constants for the touch zone hit matcher.
`timescale 1ns / 1ps
`default_nettype none
package tzhm_pkg;

    localparam int MAX_ZONES_DEF = 32;
    localparam logic [15:0] HOLDOFF_RESET = 16'd160;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // One stored zone.
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] width;
        logic signed [15:0] height;
        logic        [7:0]  action;
    } zone_t;

    // Query token that walks down the cell chain.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [7:0]  act;
    } query_t;

endpackage
`default_nettype wire

// ===== src/tzhm_cell.sv =====
// One zone cell: holds a zone and tests the passing query against it.
`timescale 1ns / 1ps
`default_nettype none
module tzhm_cell
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire tzhm_pkg::zone_t  wr_zone,
    input  wire logic             live,
    input  wire tzhm_pkg::query_t q_in,
    output tzhm_pkg::query_t      q_out
);

    tzhm_pkg::zone_t  zone_reg;
    tzhm_pkg::query_t q_reg;
    tzhm_pkg::query_t q_next;

    logic signed [16:0] x_ext;
    logic signed [16:0] y_ext;
    logic signed [16:0] left_ext;
    logic signed [16:0] top_ext;
    logic signed [16:0] right_ext;
    logic signed [16:0] bottom_ext;
    logic               inside_zone;

    // Edges widened by one bit so left + width cannot wrap.
    assign x_ext      = {q_in.x[15], q_in.x};
    assign y_ext      = {q_in.y[15], q_in.y};
    assign left_ext   = {zone_reg.left[15], zone_reg.left};
    assign top_ext    = {zone_reg.top[15], zone_reg.top};
    assign right_ext  = left_ext + {zone_reg.width[15], zone_reg.width};
    assign bottom_ext = top_ext + {zone_reg.height[15], zone_reg.height};

    assign inside_zone = (x_ext >= left_ext) && (x_ext < right_ext) &&
                         (y_ext >= top_ext) && (y_ext < bottom_ext);

    always_comb
    begin
        q_next = q_in;
        // First live match wins; later cells pass the token through.
        if (q_in.valid && !q_in.found && live && inside_zone)
        begin
            q_next.found = 1'b1;
            q_next.act   = zone_reg.action;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            zone_reg <= wr_zone;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule
`default_nettype wire

// ===== src/touch_zone_hit_matcher.sv =====
// Top level of the touch zone hit matcher: control, registers and cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Clear and add give no result. A sample not taken as a press answers in the cycle
// after acceptance. An accepted press walks the chain of MAX_ZONES cells, one per
// cycle, through the register of each cell and then the result register before it answers.
// No new item is taken while a press scans, since busy drops with the result.
// Results are one-cycle strobes on done; the receiver cannot stall. Reset (rst_n low,
// asynchronous) empties the table, clears held flag and last press time, holdoff 160.
module touch_zone_hit_matcher
#(
    parameter int MAX_ZONES = tzhm_pkg::MAX_ZONES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Item port
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] coord_x,
    input  wire logic signed [15:0] coord_y,
    input  wire logic signed [15:0] zone_w,
    input  wire logic signed [15:0] zone_h,
    input  wire logic [7:0]         zone_act,
    input  wire logic               touched,
    input  wire logic [31:0]        now_ms,
    // Result port
    output logic                    done,
    output logic [7:0]              hit_action,
    output logic                    press_accepted,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    `include "touch_zone_hit_matcher_assert.svh"

    localparam int CNT_W = $clog2(MAX_ZONES + 1);

    tzhm_pkg::state_t state_reg;
    tzhm_pkg::state_t state_next;

    logic [CNT_W-1:0] zone_count_reg;
    logic [CNT_W-1:0] zone_count_next;
    logic             press_held_reg;
    logic             press_held_next;
    logic [31:0]      last_press_reg;
    logic [31:0]      last_press_next;
    logic [15:0]      holdoff_reg;
    logic [15:0]      holdoff_next;

    logic             done_reg;
    logic             done_next;
    logic [7:0]       hit_action_reg;
    logic [7:0]       hit_action_next;
    logic             press_acc_reg;
    logic             press_acc_next;

    logic             accept;
    tzhm_pkg::op_t    op;
    logic [31:0]      elapsed;
    logic             holdoff_met;
    logic             launch;
    logic             add_ok;
    logic             cfg_wr;
    logic             press_out;
    logic             in_scan;

    tzhm_pkg::zone_t  new_zone;
    tzhm_pkg::query_t head_query;
    tzhm_pkg::query_t chain [MAX_ZONES+1];
    logic [MAX_ZONES-1:0] chain_valid;

    assign accept      = start && !busy;
    assign op          = tzhm_pkg::op_t'(opcode);
    // Wraps modulo 2^32 by construction.
    assign elapsed     = now_ms - last_press_reg;
    assign holdoff_met = elapsed >= {16'd0, holdoff_reg};

    // Launch a scan only for a fresh press past the holdoff window.
    assign launch = accept && (op == tzhm_pkg::OP_SAMPLE) && touched &&
                    !press_held_reg && holdoff_met;

    // Drop adds with action none or when the table is full.
    assign add_ok = accept && (op == tzhm_pkg::OP_ADD) && (zone_act != 8'd0) &&
                    (zone_count_reg < CNT_W'(MAX_ZONES));

    assign new_zone.left   = coord_x;
    assign new_zone.top    = coord_y;
    assign new_zone.width  = zone_w;
    assign new_zone.height = zone_h;
    assign new_zone.action = zone_act;

    assign head_query.valid = launch;
    assign head_query.found = 1'b0;
    assign head_query.x     = coord_x;
    assign head_query.y     = coord_y;
    assign head_query.act   = 8'd0;
    assign chain[0]         = head_query;

    // Cell k holds zone k; it matches only while k is below the zone count.
    // The query token moves one cell per cycle, so the first hit in insertion
    // order is the one that sticks.
    for (genvar k = 0; k < MAX_ZONES; k++)
    begin : g_cell
        tzhm_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (add_ok && (zone_count_reg == CNT_W'(k))),
            .wr_zone (new_zone),
            .live    (CNT_W'(k) < zone_count_reg),
            .q_in    (chain[k]),
            .q_out   (chain[k+1])
        );
        assign chain_valid[k] = chain[k+1].valid;
    end

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == 3'd0) ? {16'd0, holdoff_reg} : 32'd0;

    always_comb
    begin
        holdoff_next = holdoff_reg;
        if (cfg_wr && (paddr == 3'd0))
        begin
            holdoff_next = pwdata[15:0];
        end
    end

    // ---------------- State machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tzhm_pkg::ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = tzhm_pkg::ST_SCAN;
                end
            end
            tzhm_pkg::ST_SCAN:
            begin
                // Release once the token leaves the last cell.
                if (chain[MAX_ZONES].valid)
                begin
                    state_next = tzhm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tzhm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            tzhm_pkg::ST_IDLE: busy = 1'b0;
            tzhm_pkg::ST_SCAN: busy = 1'b1;
            default:           busy = 1'b1;
        endcase
    end

    // ---------------- Item handling and result ----------------
    always_comb
    begin
        zone_count_next = zone_count_reg;
        press_held_next = press_held_reg;
        last_press_next = last_press_reg;
        done_next       = 1'b0;
        hit_action_next = hit_action_reg;
        press_acc_next  = press_acc_reg;

        if (accept)
        begin
            case (op)
                tzhm_pkg::OP_CLEAR:
                begin
                    zone_count_next = '0;
                end
                tzhm_pkg::OP_ADD:
                begin
                    if (add_ok)
                    begin
                        zone_count_next = zone_count_reg + 1'b1;
                    end
                end
                tzhm_pkg::OP_SAMPLE:
                begin
                    if (!touched)
                    begin
                        press_held_next = 1'b0;
                    end
                    if (launch)
                    begin
                        press_held_next = 1'b1;
                        last_press_next = now_ms;
                    end
                    else
                    begin
                        // Rejected or released sample: answer at once.
                        done_next       = 1'b1;
                        hit_action_next = 8'd0;
                        press_acc_next  = 1'b0;
                    end
                end
                default:
                begin
                    // Unused opcode: no state change, no result.
                end
            endcase
        end

        if (chain[MAX_ZONES].valid)
        begin
            done_next       = 1'b1;
            hit_action_next = chain[MAX_ZONES].act;
            press_acc_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tzhm_pkg::ST_IDLE;
            zone_count_reg <= '0;
            press_held_reg <= 1'b0;
            last_press_reg <= 32'd0;
            holdoff_reg    <= tzhm_pkg::HOLDOFF_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            zone_count_reg <= zone_count_next;
            press_held_reg <= press_held_next;
            last_press_reg <= last_press_next;
            holdoff_reg    <= holdoff_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_action_reg <= hit_action_next;
        press_acc_reg  <= press_acc_next;
    end

    assign done           = done_reg;
    assign hit_action     = hit_action_reg;
    assign press_accepted = press_acc_reg;

    // ---------------- Assertions ----------------
    assign press_out = done_reg && press_acc_reg;
    assign in_scan   = (state_reg == tzhm_pkg::ST_SCAN);

    `TZHM_ASSERT_ALWAYS(a_one_token, $countones(chain_valid) <= 1, "more than one query in chain")
    `TZHM_ASSERT_ALWAYS(a_count_range, zone_count_reg <= CNT_W'(MAX_ZONES), "zone count overflow")
    `TZHM_ASSERT_IMPL(a_press_from_scan, press_out, $past(in_scan), "press result without scan")
    `TZHM_ASSERT_IMPL(a_press_held, press_out, press_held_reg, "press result without held flag")
    `TZHM_ASSERT_IMPL(a_scan_has_token, in_scan, chain_valid != '0, "scan state with empty chain")

endmodule
`default_nettype wire

// ===== bench/touch_zone_hit_matcher_tb.sv =====
// Self-checking testbench for the touch zone hit matcher: stimulus, driver, monitor, predictor.
`timescale 1ns / 1ps
module touch_zone_hit_matcher_tb;

    localparam int         ZONE_SLOTS   = tzhm_pkg::MAX_ZONES_DEF;
    // Opcode 3 has no meaning; the block must drop it without a result.
    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam logic [2:0] ADDR_HOLDOFF = 3'd0;
    // A press walks every zone cell before it answers; leave margin past that.
    localparam int         DRAIN_CYCLES = ZONE_SLOTS + 8;
    localparam int         PHASE_ITEMS  = 120;

    // One command toward the block, one field per port.
    typedef struct {
        logic [1:0]         opcode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [7:0]         act;
        logic               touched;
        logic [31:0]        now;
    } touch_item_t;

    // What one touch sample must report.
    typedef struct {
        logic [7:0] action;
        logic       accepted;
    } hit_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [1:0]         opcode         = '0;
    logic signed [15:0] coord_x        = '0;
    logic signed [15:0] coord_y        = '0;
    logic signed [15:0] zone_w         = '0;
    logic signed [15:0] zone_h         = '0;
    logic [7:0]         zone_act       = '0;
    logic               touched        = 1'b0;
    logic [31:0]        now_ms         = '0;
    logic               done;
    logic [7:0]         hit_action;
    logic               press_accepted;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    touch_zone_hit_matcher #(
        .MAX_ZONES (ZONE_SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .zone_w         (zone_w),
        .zone_h         (zone_h),
        .zone_act       (zone_act),
        .touched        (touched),
        .now_ms         (now_ms),
        .done           (done),
        .hit_action     (hit_action),
        .press_accepted (press_accepted),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the zone table, press tracking and
    // the holdoff register.
    // ------------------------------------------------------------------
    int          zone_l [ZONE_SLOTS];
    int          zone_tp [ZONE_SLOTS];
    int          zone_w_m [ZONE_SLOTS];
    int          zone_h_m [ZONE_SLOTS];
    logic [7:0]  zone_a [ZONE_SLOTS];
    int          zone_total  = 0;
    logic        held_m      = 1'b0;
    logic [31:0] last_press  = '0;
    logic [15:0] holdoff_m   = tzhm_pkg::HOLDOFF_RESET;

    touch_item_t pending_items [$];
    hit_result_t expected_hits [$];

    int err_count   = 0;
    int n_taken     = 0;
    int n_samples   = 0;
    int n_presses   = 0;
    int n_zone_hits = 0;
    int phase_items = 0;

    // Apply one accepted transaction to the predictor; return 1 when it yields
    // a result, with the expected fields in res.
    function automatic bit predict_hit(input touch_item_t it, output hit_result_t res);
        logic [31:0] elapsed;
        int          px;
        int          py;
        res.action   = '0;
        res.accepted = 1'b0;
        n_taken++;
        case (it.opcode)
            tzhm_pkg::OP_CLEAR:
            begin
                zone_total = 0;
                return 1'b0;
            end
            tzhm_pkg::OP_ADD:
            begin
                // Full table or no action: drop the zone.
                if (zone_total < ZONE_SLOTS && it.act != '0)
                begin
                    zone_l[zone_total]   = int'(it.x);
                    zone_tp[zone_total]  = int'(it.y);
                    zone_w_m[zone_total] = int'(it.w);
                    zone_h_m[zone_total] = int'(it.h);
                    zone_a[zone_total]   = it.act;
                    zone_total++;
                end
                return 1'b0;
            end
            tzhm_pkg::OP_SAMPLE:
            begin
                n_samples++;
                elapsed = it.now - last_press;
                if (!it.touched)
                    held_m = 1'b0;
                else if (!held_m && elapsed >= {16'h0, holdoff_m})
                begin
                    held_m       = 1'b1;
                    last_press   = it.now;
                    res.accepted = 1'b1;
                    n_presses++;
                    px = int'(it.x);
                    py = int'(it.y);
                    // First zone in insertion order wins; bounds in 32 bits, no wrap.
                    for (int i = 0; i < zone_total; i++)
                    begin
                        if (px >= zone_l[i] && px < zone_l[i] + zone_w_m[i] &&
                            py >= zone_tp[i] && py < zone_tp[i] + zone_h_m[i])
                        begin
                            res.action = zone_a[i];
                            n_zone_hits++;
                            break;
                        end
                    end
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: pop pending transactions, hold start until the block takes
    // one, then idle a random gap (with occasional back-to-back bursts)
    // before the next.
    // ------------------------------------------------------------------
    touch_item_t drv_item;
    int          idle_left  = 0;
    int          burst_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        hit_result_t res;
        int          gap;
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            gap = idle_left;
            if (start && !busy)
            begin
                // Transaction taken at this edge: predict it now.
                if (predict_hit(drv_item, res))
                    expected_hits.push_back(res);
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else
                begin
                    gap = $urandom_range(0, 15);
                    if ($urandom_range(0, 19) == 0)
                        burst_left = $urandom_range(10, 40);
                end
            end
            if (start && busy)
            begin
                // Hold the current transaction until the block is free.
            end
            else if (gap == 0 && pending_items.size() > 0)
            begin
                drv_item  = pending_items.pop_front();
                opcode    <= drv_item.opcode;
                coord_x   <= drv_item.x;
                coord_y   <= drv_item.y;
                zone_w    <= drv_item.w;
                zone_h    <= drv_item.h;
                zone_act  <= drv_item.act;
                touched   <= drv_item.touched;
                now_ms    <= drv_item.now;
                start     <= 1'b1;
                idle_left <= 0;
            end
            else
            begin
                start     <= 1'b0;
                idle_left <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done strobe is a result; match it against the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        hit_result_t want;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("result with nothing expected: hit_action %0d press_accepted %0d",
                       hit_action, press_accepted);
                err_count++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (hit_action !== want.action)
                begin
                    $error("hit_action mismatch: expected %0d, actual %0d",
                           want.action, hit_action);
                    err_count++;
                end
                if (press_accepted !== want.accepted)
                begin
                    $error("press_accepted mismatch: expected %0d, actual %0d",
                           want.accepted, press_accepted);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. The generator keeps its own list of added zones so
    // that touches can be aimed at them.
    // ------------------------------------------------------------------
    int          gen_l [ZONE_SLOTS];
    int          gen_t [ZONE_SLOTS];
    int          gen_w [ZONE_SLOTS];
    int          gen_h [ZONE_SLOTS];
    int          gen_total = 0;
    logic [31:0] clock_ms  = '0;

    task automatic push_item(input logic [1:0] op, input int x, input int y, input int w,
                             input int h, input logic [7:0] act, input logic tch,
                             input logic [31:0] stamp);
        touch_item_t it;
        it.opcode  = op;
        it.x       = 16'(x);
        it.y       = 16'(y);
        it.w       = 16'(w);
        it.h       = 16'(h);
        it.act     = act;
        it.touched = tch;
        it.now     = stamp;
        if (op == tzhm_pkg::OP_CLEAR)
            gen_total = 0;
        else if (op == tzhm_pkg::OP_ADD && act != '0 && gen_total < ZONE_SLOTS)
        begin
            gen_l[gen_total] = int'(it.x);
            gen_t[gen_total] = int'(it.y);
            gen_w[gen_total] = int'(it.w);
            gen_h[gen_total] = int'(it.h);
            gen_total++;
        end
        pending_items.push_back(it);
        phase_items++;
    endtask

    // Unused fields get random bits so every port bit toggles.
    task automatic push_sample(input logic tch, input int x, input int y);
        push_item(tzhm_pkg::OP_SAMPLE, x, y, $urandom, $urandom, 8'($urandom), tch, clock_ms);
    endtask

    task automatic push_zone(input int l, input int t, input int w, input int h,
                             input logic [7:0] act);
        push_item(tzhm_pkg::OP_ADD, l, t, w, h, act, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Mostly small zones clustered near the origin so they overlap and get
    // hit; now and then a zone with fully random geometry or no action.
    task automatic push_random_zone();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            push_zone($urandom, $urandom, $urandom, $urandom, 8'($urandom_range(0, 255)));
        else
            push_zone(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                      $urandom_range(1, 150), $urandom_range(1, 150),
                      (pick == 1) ? 8'd0 : 8'($urandom_range(1, 255)));
    endtask

    task automatic push_clear();
        push_item(tzhm_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                  1'($urandom_range(0, 1)), $urandom);
    endtask

    // Wait until the block has nothing in flight, then let the scan settle.
    // Sample at the falling edge so driver updates have landed.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || busy || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup phase, then access phase until pready.
    task automatic write_holdoff(input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HOLDOFF;
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        holdoff_m = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence: reset, directed cases on the reset holdoff, then
    // random phases at several holdoff settings with a drain in between.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          kind;
        int          x;
        int          y;
        int          z;
        int          fill;
        logic [15:0] hold_pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Press timing against the reset holdoff of 160 ms.
        clock_ms = 0;     push_sample(1'b0, 0, 0);        // idle panel
        clock_ms = 159;   push_sample(1'b1, 0, 0);        // one short of the holdoff
        clock_ms = 160;   push_sample(1'b1, 0, 0);        // exactly the holdoff, empty table
        clock_ms = 5000;  push_sample(1'b1, 0, 0);        // still held
        clock_ms = 5001;  push_sample(1'b0, 0, 0);

        // Zones at the coordinate extremes, degenerate zones, overlap.
        push_zone(-32768, -32768, 32767, 32767, 8'd255);
        push_zone(10, 10, 20, 20, 8'd0);                  // no action: dropped
        push_zone(32767, 32767, 32767, 32767, 8'd1);      // right edge past 16 bits
        push_zone(0, 0, 0, 50, 8'd7);                     // zero width never hits
        push_zone(0, 0, 50, -1, 8'd9);                    // negative height never hits
        push_zone(-100, -100, 200, 200, 8'h80);
        push_zone(-100, -100, 200, 200, 8'h81);           // shadowed by the one before

        clock_ms = 5200;  push_sample(1'b1, -32768, -32768);
        clock_ms = 5201;  push_sample(1'b0, 0, 0);
        clock_ms = 5400;  push_sample(1'b1, 32767, 32767);
        clock_ms = 5401;  push_sample(1'b0, 0, 0);
        clock_ms = 5600;  push_sample(1'b1, 0, 5);
        clock_ms = 5601;  push_sample(1'b0, 0, 0);
        clock_ms = 5700;  push_sample(1'b1, -3, -2);      // new press inside the holdoff
        clock_ms = 5701;  push_sample(1'b0, 0, 0);
        clock_ms = 5800;  push_sample(1'b1, 100, 0);      // one past the right edge
        clock_ms = 5801;  push_sample(1'b0, 0, 0);
        push_item(OP_RESERVED, $urandom, $urandom, $urandom, $urandom, 8'($urandom), 1'b1,
                  $urandom);
        push_clear();
        clock_ms = 6000;  push_sample(1'b1, -32768, -32768);  // table emptied
        clock_ms = 6001;  push_sample(1'b0, 0, 0);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_holdoff(16'd0);
                1: write_holdoff(16'hFFFF);
                2: write_holdoff(16'd1);
                3:
                begin
                    // Start just short of the timestamp wrap.
                    hold_pick = 16'($urandom_range(100, 3000));
                    write_holdoff(hold_pick);
                    clock_ms = 32'hFFFF_FC00;
                end
                default: write_holdoff(tzhm_pkg::HOLDOFF_RESET);
            endcase
            phase_items = 0;

            // Fresh table; one phase overfills it.
            push_clear();
            fill = (phase == 1) ? 40 : $urandom_range(0, 20);
            repeat (fill) push_random_zone();

            while (phase_items < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 8)
                    push_random_zone();
                else if (kind < 10)
                    push_clear();
                else if (kind == 10)
                    push_item(OP_RESERVED, $urandom, $urandom, $urandom, $urandom,
                              8'($urandom), 1'($urandom_range(0, 1)), $urandom);
                else if (kind < 25)
                begin
                    // Noise: random touch state, point and occasionally a wild time.
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms = clock_ms + $urandom_range(0, 50);
                    push_sample(1'($urandom_range(0, 1)), $urandom, $urandom);
                end
                else
                begin
                    // Release, wait out (usually) the holdoff, press, hold a bit.
                    clock_ms = clock_ms + $urandom_range(1, 20);
                    push_sample(1'b0, $urandom, $urandom);
                    if ($urandom_range(0, 4) == 0)
                        clock_ms = clock_ms + $urandom_range(0, holdoff_m);
                    else
                        clock_ms = clock_ms + 32'(holdoff_m) + $urandom_range(0, 300);
                    if (gen_total > 0 && $urandom_range(0, 9) < 7)
                    begin
                        // Aim inside a zone; the far edge is included to land just outside.
                        z = $urandom_range(0, gen_total - 1);
                        x = gen_l[z];
                        y = gen_t[z];
                        if (gen_w[z] > 0)
                            x = x + int'($urandom_range(0, gen_w[z]));
                        if (gen_h[z] > 0)
                            y = y + int'($urandom_range(0, gen_h[z]));
                        if (x > 32767)
                            x = gen_l[z];
                        if (y > 32767)
                            y = gen_t[z];
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        x = $urandom;
                        y = $urandom;
                    end
                    else
                    begin
                        x = int'($urandom_range(0, 400)) - 200;
                        y = int'($urandom_range(0, 400)) - 200;
                    end
                    push_sample(1'b1, x, y);
                    repeat ($urandom_range(0, 3))
                    begin
                        clock_ms = clock_ms + $urandom_range(1, 40);
                        push_sample(1'b1, $urandom, $urandom);
                    end
                end
            end
            // Sender pauses here until every expected result is back.
            drain();
        end

        $display("Drove %0d transactions with %0d touch samples; %0d presses taken, %0d on a zone.",
                 n_taken, n_samples, n_presses, n_zone_hits);
        $display("Holdoff ran at 0, 1, 160, 65535 and a random value, across a timestamp wrap.");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tzhm_pkg.sv
src/tzhm_cell.sv
src/touch_zone_hit_matcher.sv
bench/touch_zone_hit_matcher_tb.sv
